@@ src/nutp_pkg.sv @@
package nutp_pkg;

  localparam int CHAR_W  = 8;
  localparam int PAIR_W  = 7;
  localparam int CNT_W   = 4;
  localparam int MS_W    = 10;
  localparam int YEAR_W  = 12;
  localparam int STAT_W  = 2;

  localparam int QUEUE_DEPTH_DEF = 2;

  // field kinds
  localparam logic KIND_TIME = 1'b0;
  localparam logic KIND_DATE = 1'b1;

  // status codes, lower nonzero code has priority
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_LAYOUT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONDIGIT = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd3;

  localparam logic [PAIR_W-1:0] PIVOT_RESET = 7'd80;
  localparam logic [PAIR_W-1:0] HOUR_LIMIT  = 7'd24;
  localparam logic [PAIR_W-1:0] MINSEC_MAX  = 7'd59;
  localparam logic [MS_W:0]     MS_MAX      = 11'd999;
  localparam logic [YEAR_W-1:0] YEAR_20XX   = 12'd2000;
  localparam logic [YEAR_W-1:0] YEAR_19XX   = 12'd1900;

  localparam logic [CNT_W-1:0] CNT_MAX    = 4'd15;
  localparam logic [CNT_W-1:0] POS_DOT    = 4'd6;
  localparam logic [CNT_W-1:0] POS_FRAC0  = 4'd7;
  localparam logic [CNT_W-1:0] POS_FRAC1  = 4'd8;
  localparam logic [CNT_W-1:0] POS_FRAC2  = 4'd9;
  localparam logic [CNT_W-1:0] POS_ROUND  = 4'd10;
  localparam logic [CNT_W-1:0] LEN_PLAIN  = 4'd6;
  localparam logic [CNT_W-1:0] LEN_FRAC   = 4'd8;

  // one completed field, handed from front to back
  typedef struct packed {
    logic                kind;
    logic [CNT_W-1:0]    len;
    logic [STAT_W-1:0]   err;
    logic [PAIR_W-1:0]   p1;
    logic [PAIR_W-1:0]   p2;
    logic [PAIR_W-1:0]   p3;
    logic [MS_W-1:0]     ms;
    logic                rnd;
  } nutp_summary_t;

  function automatic logic [STAT_W-1:0] rank_err(input logic [STAT_W-1:0] have,
                                                 input logic [STAT_W-1:0] code);
    if (have == ST_OK || code < have) begin
      return code;
    end
    return have;
  endfunction

endpackage

@@ src/nutp_in_if.sv @@
interface nutp_in_if import nutp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              field_kind;
  logic              last_char;

  modport source (output valid, character, field_kind, last_char, input ready);
  modport sink   (input valid, character, field_kind, last_char, output ready);
endinterface

@@ src/nutp_out_if.sv @@
interface nutp_out_if import nutp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind_echo;
  logic [STAT_W-1:0] status;
  logic [PAIR_W-1:0] hour_or_day;
  logic [PAIR_W-1:0] minute_or_month;
  logic [PAIR_W-1:0] second_value;
  logic [MS_W-1:0]   millisecond_value;
  logic [YEAR_W-1:0] full_year;

  modport source (output valid, kind_echo, status, hour_or_day, minute_or_month,
                  second_value, millisecond_value, full_year, input ready);
  modport sink   (input valid, kind_echo, status, hour_or_day, minute_or_month,
                  second_value, millisecond_value, full_year, output ready);
endinterface

@@ src/nutp_front.sv @@
module nutp_front import nutp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [CHAR_W-1:0] ch,
  input  logic          kind,
  input  logic          last,
  output logic          push,
  output nutp_summary_t push_data
);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PAIR_W-1:0] p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  logic [MS_W-1:0]   ms_r, ms_nxt;
  logic              rnd_r, rnd_nxt;
  logic [STAT_W-1:0] err_r, err_nxt;

  logic              is_digit;
  logic [3:0]        d;
  logic [10:0]       p1_x10, p2_x10, p3_x10;

  assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
  assign d        = is_digit ? ch[3:0] : 4'd0;
  assign p1_x10   = ({4'd0, p1_r} << 3) + ({4'd0, p1_r} << 1) + {7'd0, d};
  assign p2_x10   = ({4'd0, p2_r} << 3) + ({4'd0, p2_r} << 1) + {7'd0, d};
  assign p3_x10   = ({4'd0, p3_r} << 3) + ({4'd0, p3_r} << 1) + {7'd0, d};

  always_comb begin
    err_nxt = err_r;
    p1_nxt  = p1_r;
    p2_nxt  = p2_r;
    p3_nxt  = p3_r;
    ms_nxt  = ms_r;
    rnd_nxt = rnd_r;

    if (kind == KIND_TIME && cnt_r == POS_DOT) begin
      if (ch != 8'h2E) begin
        err_nxt = rank_err(err_r, ST_LAYOUT);
      end
    end else if (!is_digit) begin
      err_nxt = rank_err(err_r, ST_NONDIGIT);
    end

    if (cnt_r < 4'd2) begin
      p1_nxt = p1_x10[PAIR_W-1:0];
    end else if (cnt_r < 4'd4) begin
      p2_nxt = p2_x10[PAIR_W-1:0];
    end else if (cnt_r < 4'd6) begin
      p3_nxt = p3_x10[PAIR_W-1:0];
    end else if (kind == KIND_TIME) begin
      case (cnt_r)
        POS_FRAC0: ms_nxt  = ms_r + MS_W'(d) * MS_W'(100);
        POS_FRAC1: ms_nxt  = ms_r + MS_W'(d) * MS_W'(10);
        POS_FRAC2: ms_nxt  = ms_r + MS_W'(d);
        POS_ROUND: rnd_nxt = (d >= 4'd5);
        default:   ;
      endcase
    end

    cnt_nxt = (cnt_r < CNT_MAX) ? cnt_r + 4'd1 : cnt_r;
  end

  assign push                = acc && last;
  assign push_data.kind      = kind;
  assign push_data.len       = cnt_nxt;
  assign push_data.err       = err_nxt;
  assign push_data.p1        = p1_nxt;
  assign push_data.p2        = p2_nxt;
  assign push_data.p3        = p3_nxt;
  assign push_data.ms        = ms_nxt;
  assign push_data.rnd       = rnd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && last)) begin
      cnt_r <= '0;
      p1_r  <= '0;
      p2_r  <= '0;
      p3_r  <= '0;
      ms_r  <= '0;
      rnd_r <= 1'b0;
      err_r <= ST_OK;
    end else if (acc) begin
      cnt_r <= cnt_nxt;
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      p3_r  <= p3_nxt;
      ms_r  <= ms_nxt;
      rnd_r <= rnd_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

@@ src/nutp_queue.sv @@
module nutp_queue import nutp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nutp_summary_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output nutp_summary_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  nutp_summary_t   mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

@@ src/nutp_back.sv @@
module nutp_back import nutp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [PAIR_W-1:0] pivot,
  input  logic              q_not_empty,
  input  nutp_summary_t     q_head,
  output logic              q_pop,
  nutp_out_if.source        out_req
);

  logic              out_valid_r;
  logic              kind_r;
  logic [STAT_W-1:0] st_r, st_nxt;
  logic [PAIR_W-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic [MS_W-1:0]   ms_r, ms_nxt;
  logic [YEAR_W-1:0] yr_r, yr_nxt;
  logic [MS_W:0]     total;

  assign q_pop = q_not_empty && (!out_valid_r || out_req.ready);
  assign total = {1'b0, q_head.ms} + {{MS_W{1'b0}}, q_head.rnd};

  always_comb begin
    st_nxt = q_head.err;
    a_nxt  = '0;
    b_nxt  = '0;
    c_nxt  = '0;
    ms_nxt = '0;
    yr_nxt = '0;

    if (q_head.kind == KIND_TIME) begin
      if (q_head.len != LEN_PLAIN && q_head.len < LEN_FRAC) begin
        st_nxt = rank_err(st_nxt, ST_LAYOUT);
      end
    end else if (q_head.len != LEN_PLAIN) begin
      st_nxt = rank_err(st_nxt, ST_LAYOUT);
    end

    if (st_nxt == ST_OK) begin
      if (q_head.kind == KIND_TIME) begin
        if (q_head.p1 >= HOUR_LIMIT || q_head.p2 > MINSEC_MAX ||
            q_head.p3 > MINSEC_MAX || total > MS_MAX) begin
          st_nxt = ST_RANGE;
        end else begin
          a_nxt  = q_head.p1;
          b_nxt  = q_head.p2;
          c_nxt  = q_head.p3;
          ms_nxt = total[MS_W-1:0];
        end
      end else begin
        a_nxt  = q_head.p1;
        b_nxt  = q_head.p2;
        yr_nxt = ((q_head.p3 < pivot) ? YEAR_20XX : YEAR_19XX) +
                 {{(YEAR_W-PAIR_W){1'b0}}, q_head.p3};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_req.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= q_head.kind;
      st_r   <= st_nxt;
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      c_r    <= c_nxt;
      ms_r   <= ms_nxt;
      yr_r   <= yr_nxt;
    end
  end

  assign out_req.valid             = out_valid_r;
  assign out_req.kind_echo         = kind_r;
  assign out_req.status            = st_r;
  assign out_req.hour_or_day       = a_r;
  assign out_req.minute_or_month   = b_r;
  assign out_req.second_value      = c_r;
  assign out_req.millisecond_value = ms_r;
  assign out_req.full_year         = yr_r;

endmodule

@@ src/nmea_utc_date_time_field_parser.sv @@
// NMEA 0183 UTC time/date field parser. Feed one character per request, tagged
// time (hhmmss[.fff...]) or date (ddmmyy), with last_char on the field's final
// character; one result comes out per field. Characters are taken one per
// cycle, back to back, while the queue is not full. A field's result is written
// into the queue when its last character is taken and moves from there into the
// output register once the output is free; besides the result held at the
// output, QUEUE_DEPTH finished fields can wait in the queue while the output
// is stalled, after which in_req.ready drops. The century pivot register
// pivot_r (reset 80) is written through cfg_we / cfg_wdata and should only
// change while no field is in flight.
module nmea_utc_date_time_field_parser import nutp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  nutp_in_if.sink           in_req,
  nutp_out_if.source        out_req,
  input  logic              cfg_we,
  input  logic [PAIR_W-1:0] cfg_wdata
);

  logic [PAIR_W-1:0] pivot_r;
  logic              acc;
  logic              push, pop, full, not_empty;
  nutp_summary_t     push_data, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_r <= PIVOT_RESET;
    end else if (cfg_we) begin
      pivot_r <= cfg_wdata;
    end
  end

  assign in_req.ready = !full;
  assign acc          = in_req.valid && !full;

  nutp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .ch        (in_req.character),
    .kind      (in_req.field_kind),
    .last      (in_req.last_char),
    .push      (push),
    .push_data (push_data)
  );

  nutp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  nutp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pivot       (pivot_r),
    .q_not_empty (not_empty),
    .q_head      (head),
    .q_pop       (pop),
    .out_req     (out_req)
  );

endmodule

@@ tb/testbench.sv @@
module testbench;
  import nutp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_CHARS = 1700;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_DOT  = 8'h2E;

  typedef struct packed {
    logic                kind;
    logic [STAT_W-1:0]   status;
    logic [PAIR_W-1:0]   hour_day;
    logic [PAIR_W-1:0]   min_month;
    logic [PAIR_W-1:0]   sec;
    logic [MS_W-1:0]     msec;
    logic [YEAR_W-1:0]   year;
  } field_result_t;

  typedef struct {
    string         text;
    logic          kind;
    bit            flip_last;
    bit            typed;
    field_result_t want;
  } field_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [PAIR_W-1:0] cfg_wdata;

  nutp_in_if  in_ch ();
  nutp_out_if out_ch ();

  nmea_utc_date_time_field_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_req   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state, mirrors one field in flight
  logic [PAIR_W-1:0] pivot;
  logic [CNT_W-1:0]  fld_count;
  logic [PAIR_W-1:0] pair_a, pair_b, pair_c;
  logic [MS_W-1:0]   frac_sum;
  logic              round_up;
  logic [STAT_W-1:0] field_err;

  field_result_t expected_fields[$];
  field_result_t got_res, want_res;
  field_row_t    dir_rows[];
  logic [CHAR_W-1:0] gen_chars[$];
  logic              gen_kinds[$];

  int mismatches;
  int sent_chars;
  int cycle_count;
  int tx_burst, rx_burst, rx_stall;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [STAT_W-1:0] keep_first_error(input logic [STAT_W-1:0] have,
                                                        input logic [STAT_W-1:0] code);
    return (have == ST_OK || code < have) ? code : have;
  endfunction

  function automatic void parse_char(input logic [CHAR_W-1:0] ch, input logic kind,
                                     input logic last, output bit got,
                                     output field_result_t res);
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  len;
    bit                dig;
    logic [3:0]        d;
    logic [STAT_W-1:0] st;
    int                total;
    pos = fld_count;
    dig = (ch >= ASCII_ZERO && ch <= ASCII_NINE);
    d = dig ? 4'(ch - ASCII_ZERO) : 4'd0;
    got = 1'b0;
    res = '0;

    // the dot slot of a time field is a layout check, not a digit check
    if (kind == KIND_TIME && pos == 4'd6) begin
      if (ch != ASCII_DOT) field_err = keep_first_error(field_err, ST_LAYOUT);
    end else if (!dig) begin
      field_err = keep_first_error(field_err, ST_NONDIGIT);
    end

    if (pos < 2)      pair_a = 7'(int'(pair_a) * 10 + d);
    else if (pos < 4) pair_b = 7'(int'(pair_b) * 10 + d);
    else if (pos < 6) pair_c = 7'(int'(pair_c) * 10 + d);
    else if (kind == KIND_TIME) begin
      if (pos == 4'd7)       frac_sum = 10'(frac_sum + d * 100);
      else if (pos == 4'd8)  frac_sum = 10'(frac_sum + d * 10);
      else if (pos == 4'd9)  frac_sum = 10'(frac_sum + d);
      else if (pos == 4'd10) round_up = (d >= 5);
    end

    if (fld_count < 4'd15) fld_count = fld_count + 1'b1;
    if (!last) return;

    len = fld_count;
    st = field_err;
    if (kind == KIND_TIME) begin
      if (len != 4'd6 && len < 4'd8) st = keep_first_error(st, ST_LAYOUT);
    end else if (len != 4'd6) begin
      st = keep_first_error(st, ST_LAYOUT);
    end

    res.kind = kind;
    if (st == ST_OK) begin
      if (kind == KIND_TIME) begin
        total = int'(frac_sum) + int'(round_up);
        if (pair_a >= 24 || pair_b > 59 || pair_c > 59 || total > 999) begin
          st = ST_RANGE;
        end else begin
          res.hour_day  = pair_a;
          res.min_month = pair_b;
          res.sec       = pair_c;
          res.msec      = 10'(total);
        end
      end else begin
        res.hour_day  = pair_a;
        res.min_month = pair_b;
        res.year = (pair_c < pivot) ? 12'(2000 + pair_c) : 12'(1900 + pair_c);
      end
    end
    res.status = st;
    got = 1'b1;

    fld_count = '0;
    pair_a = '0;
    pair_b = '0;
    pair_c = '0;
    frac_sum = '0;
    round_up = 1'b0;
    field_err = ST_OK;
  endfunction

  function automatic field_result_t want_time(input logic [STAT_W-1:0] st, input int h,
                                              input int m, input int s, input int ms);
    field_result_t r;
    r = '0;
    r.kind = KIND_TIME;
    r.status = st;
    r.hour_day = 7'(h);
    r.min_month = 7'(m);
    r.sec = 7'(s);
    r.msec = 10'(ms);
    return r;
  endfunction

  function automatic field_result_t want_date(input logic [STAT_W-1:0] st, input int dd,
                                              input int mo, input int yr);
    field_result_t r;
    r = '0;
    r.kind = KIND_DATE;
    r.status = st;
    r.hour_day = 7'(dd);
    r.min_month = 7'(mo);
    r.year = 12'(yr);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic int sender_gap();
    int r;
    if (tx_burst > 0) begin
      tx_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) tx_burst = $urandom_range(20, 80);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // results: check on the accepting edge, then pick next ready
  always @(posedge clk) begin
    int r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_res.kind      = out_ch.kind_echo;
      got_res.status    = out_ch.status;
      got_res.hour_day  = out_ch.hour_or_day;
      got_res.min_month = out_ch.minute_or_month;
      got_res.sec       = out_ch.second_value;
      got_res.msec      = out_ch.millisecond_value;
      got_res.year      = out_ch.full_year;
      if (expected_fields.size() == 0) begin
        report_mismatch("result with nothing pending, status", got_res.status, 0);
      end else begin
        want_res = expected_fields.pop_front();
        if (got_res.kind !== want_res.kind)
          report_mismatch("kind_echo", got_res.kind, want_res.kind);
        if (got_res.status !== want_res.status)
          report_mismatch("status", got_res.status, want_res.status);
        if (got_res.hour_day !== want_res.hour_day)
          report_mismatch("hour_or_day", got_res.hour_day, want_res.hour_day);
        if (got_res.min_month !== want_res.min_month)
          report_mismatch("minute_or_month", got_res.min_month, want_res.min_month);
        if (got_res.sec !== want_res.sec)
          report_mismatch("second_value", got_res.sec, want_res.sec);
        if (got_res.msec !== want_res.msec)
          report_mismatch("millisecond_value", got_res.msec, want_res.msec);
        if (got_res.year !== want_res.year)
          report_mismatch("full_year", got_res.year, want_res.year);
      end
    end

    if (rx_burst > 0) begin
      rx_burst--;
      out_ch.ready <= 1'b1;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 3) rx_burst = $urandom_range(20, 80);
      else if (r < 70) rx_stall = 0;
      else if (r < 92) rx_stall = $urandom_range(1, 3);
      else rx_stall = $urandom_range(4, 30);
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic kind, input logic last,
                           input bit typed, input field_result_t want);
    int gap;
    bit got;
    field_result_t res;
    gap = sender_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.character  <= ch;
    in_ch.field_kind <= kind;
    in_ch.last_char  <= last;
    do @(posedge clk); while (!in_ch.ready);
    parse_char(ch, kind, last, got, res);
    if (got) expected_fields.push_back(typed ? want : res);
    sent_chars++;
  endtask

  // only between fields, with every result drained
  task automatic set_pivot(input logic [PAIR_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pivot = v;
  endtask

  task automatic push_pair(input int v);
    gen_chars.push_back(ASCII_ZERO + 8'(v / 10));
    gen_chars.push_back(ASCII_ZERO + 8'(v % 10));
  endtask

  task automatic build_field();
    int r, n, p;
    logic kind;
    logic [CHAR_W-1:0] c;
    gen_chars.delete();
    gen_kinds.delete();
    kind = $urandom_range(0, 1);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      n = $urandom_range(1, 16);
      repeat (n) begin
        if ($urandom_range(0, 1)) c = ASCII_ZERO + 8'($urandom_range(0, 9));
        else c = 8'($urandom_range(0, 255));
        gen_chars.push_back(c);
      end
    end else if (kind == KIND_TIME) begin
      push_pair(r < 80 ? $urandom_range(0, 23) : $urandom_range(0, 99));
      push_pair(r < 85 ? $urandom_range(0, 59) : $urandom_range(0, 99));
      push_pair(r < 90 ? $urandom_range(0, 59) : $urandom_range(0, 99));
      if ($urandom_range(0, 3) != 0) begin
        gen_chars.push_back(ASCII_DOT);
        n = $urandom_range(1, 12);
        // a run of nines pushes the rounding toward a full second
        p = ($urandom_range(0, 7) == 0) ? 3 : 0;
        for (int i = 0; i < n; i++) begin
          if (i < p) gen_chars.push_back(ASCII_NINE);
          else gen_chars.push_back(ASCII_ZERO + 8'($urandom_range(0, 9)));
        end
      end
    end else begin
      push_pair($urandom_range(0, 99));
      push_pair($urandom_range(0, 99));
      push_pair($urandom_range(0, 99));
    end
    foreach (gen_chars[i]) gen_kinds.push_back(kind);

    r = $urandom_range(0, 99);
    p = $urandom_range(0, gen_chars.size() - 1);
    if (r < 6) begin
      gen_chars[p] = 8'($urandom_range(0, 255));
    end else if (r < 10) begin
      while (gen_chars.size() > p + 1) begin
        void'(gen_chars.pop_back());
        void'(gen_kinds.pop_back());
      end
    end else if (r < 13) begin
      gen_chars.push_back($urandom_range(0, 1) ? ASCII_ZERO + 8'($urandom_range(0, 9))
                                               : 8'($urandom_range(0, 255)));
      gen_kinds.push_back(kind);
    end else if (r < 16) begin
      gen_kinds[p] = ~gen_kinds[p];
    end
  endtask

  task automatic run_random(input int count);
    int stop_at;
    field_result_t none;
    none = '0;
    stop_at = sent_chars + count;
    while (sent_chars < stop_at) begin
      build_field();
      foreach (gen_chars[i])
        send_char(gen_chars[i], gen_kinds[i], i == gen_chars.size() - 1, 1'b0, none);
    end
  endtask

  initial begin
    logic [PAIR_W-1:0] phase_pivots[$];
    int len;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.character = '0;
    in_ch.field_kind = KIND_TIME;
    in_ch.last_char = 1'b0;
    sent_chars = 0;
    tx_burst = 0;
    pivot = 7'd80;
    fld_count = '0;
    pair_a = '0;
    pair_b = '0;
    pair_c = '0;
    frac_sum = '0;
    round_up = 1'b0;
    field_err = ST_OK;

    dir_rows = '{
      '{"000000",      KIND_TIME, 1'b0, 1'b1, want_time(ST_OK, 0, 0, 0, 0)},
      '{"235959.9994", KIND_TIME, 1'b0, 1'b1, want_time(ST_OK, 23, 59, 59, 999)},
      '{"235959.9995", KIND_TIME, 1'b0, 1'b1, want_time(ST_RANGE, 0, 0, 0, 0)},
      '{"240000",      KIND_TIME, 1'b0, 1'b1, want_time(ST_RANGE, 0, 0, 0, 0)},
      '{"126000",      KIND_TIME, 1'b0, 1'b1, want_time(ST_RANGE, 0, 0, 0, 0)},
      '{"120060",      KIND_TIME, 1'b0, 1'b1, want_time(ST_RANGE, 0, 0, 0, 0)},
      '{"123456.5",    KIND_TIME, 1'b0, 1'b1, want_time(ST_OK, 12, 34, 56, 500)},
      '{"123456.",     KIND_TIME, 1'b0, 1'b1, want_time(ST_LAYOUT, 0, 0, 0, 0)},
      '{"12345",       KIND_TIME, 1'b0, 1'b1, want_time(ST_LAYOUT, 0, 0, 0, 0)},
      '{"1234567.5",   KIND_TIME, 1'b0, 1'b1, want_time(ST_LAYOUT, 0, 0, 0, 0)},
      '{"12a456",      KIND_TIME, 1'b0, 1'b1, want_time(ST_NONDIGIT, 0, 0, 0, 0)},
      '{"12a456x",     KIND_TIME, 1'b0, 1'b1, want_time(ST_LAYOUT, 0, 0, 0, 0)},
      '{"\377",        KIND_TIME, 1'b0, 1'b1, want_time(ST_LAYOUT, 0, 0, 0, 0)},
      '{"000000.0009", KIND_TIME, 1'b0, 1'b0, '0},
      '{"000000.123456789012345", KIND_TIME, 1'b0, 1'b0, '0},
      '{"311279",      KIND_DATE, 1'b0, 1'b1, want_date(ST_OK, 31, 12, 2079)},
      '{"010180",      KIND_DATE, 1'b0, 1'b1, want_date(ST_OK, 1, 1, 1980)},
      '{"999999",      KIND_DATE, 1'b0, 1'b1, want_date(ST_OK, 99, 99, 1999)},
      '{"1201999",     KIND_DATE, 1'b0, 1'b1, want_date(ST_LAYOUT, 0, 0, 0)},
      '{"12.199",      KIND_DATE, 1'b0, 1'b1, want_date(ST_NONDIGIT, 0, 0, 0)},
      '{"123456",      KIND_TIME, 1'b1, 1'b0, '0},
      '{"010203",      KIND_DATE, 1'b1, 1'b0, '0},
      '{"123456.5",    KIND_DATE, 1'b1, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      len = dir_rows[r].text.len();
      for (int i = 0; i < len; i++)
        send_char(dir_rows[r].text[i],
                  (dir_rows[r].flip_last && i == len - 1) ? ~dir_rows[r].kind
                                                           : dir_rows[r].kind,
                  i == len - 1, dir_rows[r].typed, dir_rows[r].want);
    end
    run_random(RANDOM_CHARS / 9);

    phase_pivots = '{7'd0, 7'd127, 7'd99, 7'd100, 7'd1, 7'd80,
                     7'($urandom_range(0, 127)), 7'($urandom_range(0, 99))};
    foreach (phase_pivots[p]) begin
      set_pivot(phase_pivots[p]);
      run_random(RANDOM_CHARS / 9);
    end

    in_ch.valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ nmea_utc_date_time_field_parser.f @@
src/nutp_pkg.sv
src/nutp_in_if.sv
src/nutp_out_if.sv
src/nutp_front.sv
src/nutp_queue.sv
src/nutp_back.sv
src/nmea_utc_date_time_field_parser.sv
tb/testbench.sv
